// File: rtl/mcd_pkg.sv
// mcd_pkg: shared types, constants and segment decode for the mm:ss countdown timer
// no dependencies; imported by mcd_core, mcd_out_buf and the top level

package mcd_pkg;

    // reset value of the ticks-per-second register
    localparam logic [15:0] TPS_RESET = 16'd1000;

    // load limits
    localparam logic [6:0] MINUTES_MAX = 7'd99;
    localparam logic [5:0] SECONDS_MAX = 6'd59;

    // reciprocal of ten, scaled by 2^11, exact for values below 100
    localparam logic [14:0] RECIP10      = 15'd205;
    localparam int          RECIP10_SHFT = 11;

    // wrap values for the borrow chain
    localparam logic [3:0] DIGIT_WRAP    = 4'd9;
    localparam logic [2:0] SEC_TENS_WRAP = 3'd5;

    // display defaults
    localparam logic [3:0] SELECT_OFF = 4'hF;
    localparam logic [7:0] SEG_DP     = 8'h80;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_START  = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_PAUSE  = 2'd3
    } t_req_type;

    // scan positions
    typedef enum logic [1:0] {
        SCAN_MIN_TENS = 2'd0,
        SCAN_MIN_ONES = 2'd1,
        SCAN_SEC_TENS = 2'd2,
        SCAN_SEC_ONES = 2'd3
    } t_scan_pos;

    // one result beat
    typedef struct packed {
        logic [3:0] digit_select;
        logic [7:0] segments;
        logic [6:0] minutes_left;
        logic [5:0] seconds_left;
        logic       running;
        logic       expired;
    } t_res;

    // seven-segment pattern of one BCD digit, blank above nine
    function automatic logic [7:0] seg_decode(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3f;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5b;
            4'd3:    pat = 8'h4f;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6d;
            4'd6:    pat = 8'h7d;
            4'd7:    pat = 8'h27;
            4'd8:    pat = 8'h7f;
            4'd9:    pat = 8'h67;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/mcd_req_if.sv
// mcd_req_if: request channel (valid, ready, request payload)
// depends on nothing beyond plain logic types

interface mcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] load_minutes;
    logic [5:0] load_seconds;

    modport source (output valid, output req_type, output load_minutes,
                    output load_seconds, input ready);
    modport sink   (input valid, input req_type, input load_minutes,
                    input load_seconds, output ready);
endinterface

// File: rtl/mcd_res_if.sv
// mcd_res_if: result channel (valid, ready, display and status payload)
// depends on nothing beyond plain logic types

interface mcd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_select;
    logic [7:0] segments;
    logic [6:0] minutes_left;
    logic [5:0] seconds_left;
    logic       running;
    logic       expired;

    modport source (output valid, output digit_select, output segments,
                    output minutes_left, output seconds_left, output running,
                    output expired, input ready);
    modport sink   (input valid, input digit_select, input segments,
                    input minutes_left, input seconds_left, input running,
                    input expired, output ready);
endinterface

// File: rtl/mmss_countdown_timer_7seg.sv
// mmss_countdown_timer_7seg: top level of the mm:ss countdown timer with 7-segment scan
// depends on mcd_pkg, mcd_req_if, mcd_res_if, mcd_core and mcd_out_buf
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    req_type, load_minutes, load_seconds
//   o_res    out  valid/ready    digit_select, segments, minutes_left,
//                                seconds_left, running, expired
//   cfg      in   i_cfg_we       i_cfg_wdata (ticks per second)
//
// one request beat per cycle; its result is ready in the buffer in the next cycle
// the two-entry result buffer sets the rate: requests stall only while it is full
// i_rst_n is synchronous, active low: timer stopped at 00:00, display blank,
// ticks per second back to 1000
// every request beat gives exactly one result beat, in order

module mmss_countdown_timer_7seg import mcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mcd_req_if.sink     i_req,
    mcd_res_if.source   o_res
);

    logic acc;
    logic buf_full;
    t_res core_res;
    t_res buf_res;

    // request handshake
    assign i_req.ready = !buf_full;
    assign acc         = i_req.valid && !buf_full;

    mcd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_acc          (acc),
        .i_req_type     (i_req.req_type),
        .i_load_minutes (i_req.load_minutes),
        .i_load_seconds (i_req.load_seconds),
        .o_res          (core_res)
    );

    mcd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (acc),
        .i_data  (core_res),
        .o_full  (buf_full),
        .o_valid (o_res.valid),
        .i_rd    (o_res.ready),
        .o_data  (buf_res)
    );

    // result payload
    assign o_res.digit_select = buf_res.digit_select;
    assign o_res.segments     = buf_res.segments;
    assign o_res.minutes_left = buf_res.minutes_left;
    assign o_res.seconds_left = buf_res.seconds_left;
    assign o_res.running      = buf_res.running;
    assign o_res.expired      = buf_res.expired;

endmodule

// File: rtl/mcd_core.sv
// mcd_core: timer state, prescaler, BCD borrow chain and display scan
// depends on mcd_pkg; result beat goes to mcd_out_buf

module mcd_core import mcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_acc,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_load_minutes,
    input  logic [5:0]  i_load_seconds,
    output t_res        o_res
);

    logic [15:0] r_tps;
    logic [15:0] r_presc,  n_presc;
    logic [3:0]  r_min_t,  n_min_t;
    logic [3:0]  r_min_o,  n_min_o;
    logic [2:0]  r_sec_t,  n_sec_t;
    logic [3:0]  r_sec_o,  n_sec_o;
    logic        r_active, n_active;
    logic [1:0]  r_scan,   n_scan;
    logic [3:0]  r_sel,    n_sel;
    logic [7:0]  r_seg,    n_seg;
    logic        n_expired;

    t_req_type   req;
    logic [6:0]  lm_sat;
    logic [5:0]  ls_sat;
    logic [14:0] lm_prod;
    logic [14:0] ls_prod;
    logic [3:0]  lm_tens;
    logic [2:0]  ls_tens;
    logic [15:0] presc_inc;
    logic        sec_done;

    assign req = t_req_type'(i_req_type);

    // saturate the load and split it into digits by reciprocal multiply
    assign lm_sat  = (i_load_minutes > MINUTES_MAX) ? MINUTES_MAX : i_load_minutes;
    assign ls_sat  = (i_load_seconds > SECONDS_MAX) ? SECONDS_MAX : i_load_seconds;
    assign lm_prod = 15'(lm_sat) * RECIP10;
    assign ls_prod = 15'(ls_sat) * RECIP10;
    assign lm_tens = lm_prod[RECIP10_SHFT +: 4];
    assign ls_tens = ls_prod[RECIP10_SHFT +: 3];

    // prescaler compare
    assign presc_inc = r_presc + 16'd1;
    assign sec_done  = (presc_inc >= r_tps);

    // next state
    always_comb begin
        n_presc   = r_presc;
        n_min_t   = r_min_t;
        n_min_o   = r_min_o;
        n_sec_t   = r_sec_t;
        n_sec_o   = r_sec_o;
        n_active  = r_active;
        n_scan    = r_scan;
        n_sel     = r_sel;
        n_seg     = r_seg;
        n_expired = 1'b0;
        case (req)
            REQ_START: begin
                n_min_t  = lm_tens;
                n_min_o  = 4'(lm_sat - 7'(lm_tens) * 7'd10);
                n_sec_t  = ls_tens;
                n_sec_o  = 4'(ls_sat - 6'(ls_tens) * 6'd10);
                n_active = 1'b1;
            end
            REQ_CANCEL: begin
                n_min_t  = '0;
                n_min_o  = '0;
                n_sec_t  = '0;
                n_sec_o  = '0;
                n_active = 1'b0;
            end
            REQ_PAUSE: begin
                n_active = 1'b0;
            end
            default: begin
                n_presc = sec_done ? 16'd0 : presc_inc;
                // borrow chain, seconds tens wraps to five
                if (sec_done && r_active) begin
                    if (r_sec_o != 4'd0) begin
                        n_sec_o = r_sec_o - 4'd1;
                    end else begin
                        n_sec_o = DIGIT_WRAP;
                        if (r_sec_t != 3'd0) begin
                            n_sec_t = r_sec_t - 3'd1;
                        end else begin
                            n_sec_t = SEC_TENS_WRAP;
                            if (r_min_o != 4'd0) begin
                                n_min_o = r_min_o - 4'd1;
                            end else begin
                                n_min_o = DIGIT_WRAP;
                                n_min_t = (r_min_t != 4'd0) ? r_min_t - 4'd1 : DIGIT_WRAP;
                            end
                        end
                    end
                    if (n_min_t == 4'd0 && n_min_o == 4'd0 &&
                        n_sec_t == 3'd0 && n_sec_o == 4'd0) begin
                        n_expired = 1'b1;
                        n_active  = 1'b0;
                    end
                end
                // drive one digit of the display
                n_sel = ~(4'b0001 << r_scan);
                case (t_scan_pos'(r_scan))
                    SCAN_MIN_TENS: n_seg = seg_decode(n_min_t);
                    SCAN_MIN_ONES: n_seg = seg_decode(n_min_o) | SEG_DP;
                    SCAN_SEC_TENS: n_seg = seg_decode({1'b0, n_sec_t});
                    default:       n_seg = seg_decode(n_sec_o);
                endcase
                n_scan = r_scan + 2'd1;
            end
        endcase
    end

    // result beat from the updated state
    always_comb begin
        o_res.digit_select = n_sel;
        o_res.segments     = n_seg;
        o_res.minutes_left = 7'(n_min_t) * 7'd10 + 7'(n_min_o);
        o_res.seconds_left = 6'(n_sec_t) * 6'd10 + 6'(n_sec_o);
        o_res.running      = n_active;
        o_res.expired      = n_expired;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    // timer state, updated on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc  <= '0;
            r_min_t  <= '0;
            r_min_o  <= '0;
            r_sec_t  <= '0;
            r_sec_o  <= '0;
            r_active <= 1'b0;
            r_scan   <= '0;
            r_sel    <= SELECT_OFF;
            r_seg    <= '0;
        end else if (i_acc) begin
            r_presc  <= n_presc;
            r_min_t  <= n_min_t;
            r_min_o  <= n_min_o;
            r_sec_t  <= n_sec_t;
            r_sec_o  <= n_sec_o;
            r_active <= n_active;
            r_scan   <= n_scan;
            r_sel    <= n_sel;
            r_seg    <= n_seg;
        end
    end

    // digits stay in BCD range
    a_digits_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_t <= DIGIT_WRAP && r_min_o <= DIGIT_WRAP &&
        r_sec_t <= SEC_TENS_WRAP && r_sec_o <= DIGIT_WRAP)
        else $error("timer digit out of BCD range");

    // an expiring beat shows 00:00 and a stopped timer
    a_expire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && o_res.expired) |->
        (!o_res.running && o_res.minutes_left == 7'd0 && o_res.seconds_left == 6'd0))
        else $error("expired beat without 00:00 or still running");

    // at most one digit is enabled
    a_select_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_sel) >= 3)
        else $error("more than one digit selected");

    // the scan moves only on an accepted tick
    a_scan_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_acc && req == REQ_TICK) |=> $stable(r_scan))
        else $error("scan position moved without a tick");

endmodule

// File: rtl/mcd_out_buf.sv
// mcd_out_buf: two-entry result buffer between the core and the result channel
// depends on mcd_pkg for the result beat type

module mcd_out_buf import mcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_rd,
    output t_res o_data
);

    t_res       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_rd;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_wr) - 2'(pop);
        end
    end

    // never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write into full result buffer");

    // fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer count out of range");

    // pointers agree with the count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) == (r_count == 2'd0 || r_count == 2'd2))
        else $error("result buffer pointers disagree with count");

endmodule
